// ----- rtl/brbff_pkg.sv -----
package brbff_pkg;

	localparam int unsigned VALUE_W  = 8;
	localparam int unsigned LENGTH_W = 16;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned ANSWER_W = 9;
	localparam int unsigned COUNT_W  = 8;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_FILL  = 2'd1;
	localparam logic [1:0] CMD_FIND  = 2'd2;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_FILL,
		OP_FIND,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [VALUE_W-1:0]  value;
		logic [LENGTH_W-1:0] length;
		logic                clamp;
		logic [OFFSET_W-1:0] offset;
	} req_t;

endpackage

// ----- rtl/byte_ring_buffer_fill_find.sv -----
// Byte ring buffer with overwrite: CAPACITY+1 byte slots, one kept free.
// Request channel: push/full queue. A request is taken on a clock edge with
// push high and full low; a two-entry queue holds requests while the engine
// is busy. Result channel: empty/pop queue. The oldest result is on answer,
// used_count, free_count, is_full and is_empty while empty is low and is
// taken on an edge with pop high. Exactly one result per request, in order.
// A clear or unused command goes straight to the report state. A fill
// writes one store byte per cycle; a find reads one store byte per cycle,
// with the read data registered before the compare.
// One request is worked on at a time; the next queued request is taken
// only once the result register is empty, after the result is popped.
// If pop stays low the result register holds; the engine then stops before
// its next request and the request queue fills, raising full.
// Reset (arst_n low) empties the buffer, both queues and the result register.
// Store contents are not cleared; only written bytes are ever read.
module byte_ring_buffer_fill_find #(
	parameter int unsigned CAPACITY = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          cmd,
	input  logic [brbff_pkg::VALUE_W-1:0]       byte_value,
	input  logic [brbff_pkg::LENGTH_W-1:0]      length,
	input  logic [brbff_pkg::OFFSET_W-1:0]      start_offset,
	output logic                                empty,
	input  logic                                pop,
	output logic [brbff_pkg::ANSWER_W-1:0]      answer,
	output logic [brbff_pkg::COUNT_W-1:0]       used_count,
	output logic [brbff_pkg::COUNT_W-1:0]       free_count,
	output logic                                is_full,
	output logic                                is_empty
);

	logic            q_valid;
	logic            q_pop;
	brbff_pkg::req_t q_req;

	brbff_front #(
		.CAPACITY(CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.byte_value  (byte_value),
		.length      (length),
		.start_offset(start_offset),
		.q_valid     (q_valid),
		.q_req       (q_req),
		.q_pop       (q_pop)
	);

	brbff_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.answer    (answer),
		.used_count(used_count),
		.free_count(free_count),
		.is_full   (is_full),
		.is_empty  (is_empty)
	);

endmodule

// ----- rtl/brbff_front.sv -----
module brbff_front #(
	parameter int unsigned CAPACITY = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          cmd,
	input  logic [brbff_pkg::VALUE_W-1:0]       byte_value,
	input  logic [brbff_pkg::LENGTH_W-1:0]      length,
	input  logic [brbff_pkg::OFFSET_W-1:0]      start_offset,
	output logic                                q_valid,
	output brbff_pkg::req_t                     q_req,
	input  logic                                q_pop
);

	localparam int unsigned SLOTS = CAPACITY + 1;
	localparam int unsigned LCW   = brbff_pkg::LENGTH_W + 1;
	localparam int unsigned QPW   = brbff_pkg::QUEUE_PW;
	localparam int unsigned DEPTH = brbff_pkg::QUEUE_DEPTH;

	brbff_pkg::req_t in_req;
	brbff_pkg::req_t entry_q [DEPTH];
	logic [QPW-1:0]  wr_ptr_q;
	logic [QPW-1:0]  rd_ptr_q;
	logic [QPW:0]    cnt_q;
	logic            do_push;
	logic            do_pop;

	always_comb begin
		unique case (cmd)
			brbff_pkg::CMD_CLEAR: in_req.op = brbff_pkg::OP_CLEAR;
			brbff_pkg::CMD_FILL:  in_req.op = brbff_pkg::OP_FILL;
			brbff_pkg::CMD_FIND:  in_req.op = brbff_pkg::OP_FIND;
			default:              in_req.op = brbff_pkg::OP_NONE;
		endcase
		in_req.value  = byte_value;
		in_req.length = length;
		// fill count saturates at the slot count
		in_req.clamp  = {1'b0, length} >= LCW'(SLOTS);
		in_req.offset = start_offset;
	end

	assign full    = cnt_q == (QPW+1)'(DEPTH);
	assign q_valid = cnt_q != '0;
	assign q_req   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/brbff_back.sv -----
module brbff_back #(
	parameter int unsigned CAPACITY = 255
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  brbff_pkg::req_t                     q_req,
	output logic                                q_pop,
	output logic                                empty,
	input  logic                                pop,
	output logic [brbff_pkg::ANSWER_W-1:0]      answer,
	output logic [brbff_pkg::COUNT_W-1:0]       used_count,
	output logic [brbff_pkg::COUNT_W-1:0]       free_count,
	output logic                                is_full,
	output logic                                is_empty
);

	localparam int unsigned SLOTS = CAPACITY + 1;
	localparam int unsigned PW    = $clog2(SLOTS);
	localparam int unsigned CW    = $clog2(SLOTS + 1);
	localparam int unsigned KW    = (PW > brbff_pkg::OFFSET_W) ? PW : brbff_pkg::OFFSET_W;
	localparam int unsigned SW    = KW + 1;
	localparam int unsigned AW    = brbff_pkg::ANSWER_W;
	localparam int unsigned NW    = brbff_pkg::COUNT_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FILL   = 4'b0010,
		ST_FIND   = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [PW-1:0]                  wp_q;
	logic [PW-1:0]                  rp_q;
	logic [CW-1:0]                  rem_q;
	logic                           ovf_q;
	logic [brbff_pkg::VALUE_W-1:0]  value_q;
	logic [AW-1:0]                  ans_q;
	logic [KW-1:0]                  k_q;
	logic [KW-1:0]                  k_s1;
	logic                           pend_s1;
	logic [brbff_pkg::VALUE_W-1:0]  rdata_s1;
	logic                           out_valid_q;
	logic [AW-1:0]                  answer_q;
	logic [NW-1:0]                  used_count_q;
	logic [NW-1:0]                  free_count_q;
	logic                           is_full_q;
	logic                           is_empty_q;
	logic [brbff_pkg::VALUE_W-1:0]  mem_q [SLOTS];

	logic [PW:0]    diff;
	logic [PW-1:0]  used;
	logic [PW-1:0]  free;
	logic [PW-1:0]  wp_next;
	logic [CW-1:0]  req_count;
	logic           fill_ovf;
	logic           k_hit;
	logic [SW-1:0]  addr_sum;
	logic [PW-1:0]  find_addr;
	logic           match;
	logic           take;
	logic           mem_we;
	logic           mem_re;

	always_comb begin
		diff = {1'b0, wp_q} - {1'b0, rp_q} + ((wp_q < rp_q) ? (PW+1)'(SLOTS) : '0);
		used = PW'(diff);
		free = PW'(CAPACITY) - used;
		wp_next = (wp_q == PW'(CAPACITY)) ? '0 : wp_q + PW'(1);
		req_count = q_req.clamp ? CW'(SLOTS) : CW'(q_req.length);
		fill_ovf = req_count > CW'(free);
		k_hit = k_q < KW'(used);
		addr_sum = SW'(rp_q) + SW'(k_q);
		find_addr = (addr_sum >= SW'(SLOTS)) ? PW'(addr_sum - SW'(SLOTS)) : PW'(addr_sum);
		match = pend_s1 && (rdata_s1 == value_q);
	end

	assign take   = (state_q == ST_IDLE) && q_valid && !out_valid_q;
	assign q_pop  = take;
	assign mem_we = (state_q == ST_FILL) && (rem_q != '0);
	assign mem_re = (state_q == ST_FIND) && !match && k_hit;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wp_q] <= value_q;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[find_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			rem_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (q_req.op)
							brbff_pkg::OP_CLEAR: begin
								wp_q    <= '0;
								rp_q    <= '0;
								state_q <= ST_REPORT;
							end
							brbff_pkg::OP_FILL: begin
								rem_q   <= req_count;
								state_q <= ST_FILL;
							end
							brbff_pkg::OP_FIND: begin
								pend_s1 <= 1'b0;
								state_q <= ST_FIND;
							end
							default: begin
								state_q <= ST_REPORT;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (rem_q == '0) begin
						// overwrite: oldest byte sits one past the write slot
						if (ovf_q) begin
							rp_q <= wp_next;
						end
						state_q <= ST_REPORT;
					end else begin
						wp_q  <= wp_next;
						rem_q <= rem_q - CW'(1);
					end
				end
				ST_FIND: begin
					if (match || !k_hit) begin
						pend_s1 <= 1'b0;
						state_q <= ST_REPORT;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_REPORT) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= q_req.value;
			ovf_q   <= fill_ovf;
			k_q     <= KW'(q_req.offset);
			ans_q   <= (q_req.op == brbff_pkg::OP_FILL) ? AW'(req_count) : '0;
		end
		if (mem_re) begin
			k_s1 <= k_q;
			k_q  <= k_q + KW'(1);
		end
		if (state_q == ST_FIND) begin
			if (match) begin
				ans_q <= AW'(k_s1);
			end else if (!k_hit) begin
				ans_q <= AW'(used);
			end
		end
		if (state_q == ST_REPORT) begin
			answer_q     <= ans_q;
			used_count_q <= NW'(used);
			free_count_q <= NW'(free);
			is_full_q    <= free == '0;
			is_empty_q   <= used == '0;
		end
	end

	assign empty      = !out_valid_q;
	assign answer     = answer_q;
	assign used_count = used_count_q;
	assign free_count = free_count_q;
	assign is_full    = is_full_q;
	assign is_empty   = is_empty_q;

endmodule

// ----- rtl/brbff_chk.sv -----
module brbff_chk #(
	parameter int unsigned CAPACITY = 255
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                empty,
	input logic                                pop,
	input logic [brbff_pkg::ANSWER_W-1:0]      answer,
	input logic [brbff_pkg::COUNT_W-1:0]       used_count,
	input logic [brbff_pkg::COUNT_W-1:0]       free_count,
	input logic                                is_full,
	input logic                                is_empty
);

	localparam int unsigned NW = brbff_pkg::COUNT_W;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(is_full && is_empty))
		else $error("full and empty flagged together");

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (NW'(used_count + free_count) == NW'(CAPACITY)))
		else $error("used plus free does not match capacity");

	a_empty_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_empty) |-> (used_count == '0 && free_count == NW'(CAPACITY)))
		else $error("empty flag with nonzero occupancy");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(answer) && $stable(used_count)))
		else $error("stalled result changed");

endmodule

bind byte_ring_buffer_fill_find brbff_chk #(
	.CAPACITY(CAPACITY)
) u_brbff_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.answer    (answer),
	.used_count(used_count),
	.free_count(free_count),
	.is_full   (is_full),
	.is_empty  (is_empty)
);
